@@ rtl/qtm_pkg.sv @@
// ----------------------------------------------------------------------------
// qtm_pkg
// Types, constants and arithmetic helpers for the quaternion to model matrix
// pipeline.
// ----------------------------------------------------------------------------
package qtm_pkg;

	// one in Q.28, the format of the doubled quaternion products
	localparam int ONE_FRAC = 28;
	// Q.36 to Q16.16
	localparam int RND_SHIFT = 20;
	localparam int TERM_W = 35;
	localparam int PROD_W = 33;
	localparam int SCL_W = TERM_W + 16;

	localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd1 <<< ONE_FRAC);
	localparam logic signed [SCL_W-1:0] RND_HALF = SCL_W'(64'sd1 <<< (RND_SHIFT - 1));

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} qtm_in_t;

	typedef struct packed {
		logic signed [31:0] col0_x;
		logic signed [31:0] col0_y;
		logic signed [31:0] col0_z;
		logic signed [31:0] col1_x;
		logic signed [31:0] col1_y;
		logic signed [31:0] col1_z;
		logic signed [31:0] col2_x;
		logic signed [31:0] col2_y;
		logic signed [31:0] col2_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} qtm_out_t;

	// doubled quaternion products, Q.28
	typedef struct packed {
		logic signed [PROD_W-1:0] xx;
		logic signed [PROD_W-1:0] xy;
		logic signed [PROD_W-1:0] xz;
		logic signed [PROD_W-1:0] yy;
		logic signed [PROD_W-1:0] yz;
		logic signed [PROD_W-1:0] zz;
		logic signed [PROD_W-1:0] wx;
		logic signed [PROD_W-1:0] wy;
		logic signed [PROD_W-1:0] wz;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} qtm_prod_t;

	// unscaled rotation entries, column-major, Q.28
	typedef struct packed {
		logic signed [8:0][TERM_W-1:0] ent;
		logic signed [15:0] scale_x;
		logic signed [15:0] scale_y;
		logic signed [15:0] scale_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} qtm_term_t;

	// scaled entries, Q.36
	typedef struct packed {
		logic signed [8:0][SCL_W-1:0] ent;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} qtm_scl_t;

	function automatic logic signed [PROD_W-1:0] dbl_mul(
		input logic signed [15:0] a,
		input logic signed [15:0] b
	);
		logic signed [31:0] p;
		p = a * b;
		return {p, 1'b0};
	endfunction

	function automatic logic signed [TERM_W-1:0] ext_term(input logic signed [PROD_W-1:0] a);
		return TERM_W'(a);
	endfunction

	function automatic logic signed [SCL_W-1:0] scl_mul(
		input logic signed [TERM_W-1:0] t,
		input logic signed [15:0] s
	);
		logic signed [SCL_W-1:0] a;
		logic signed [SCL_W-1:0] b;
		a = SCL_W'(t);
		b = SCL_W'(s);
		return a * b;
	endfunction

	// round to nearest, ties up; magnitude stays below 2^28 so taking the low 32 bits loses nothing
	function automatic logic signed [31:0] rnd_q16(input logic signed [SCL_W-1:0] p);
		logic signed [SCL_W-1:0] r;
		r = (p + RND_HALF) >>> RND_SHIFT;
		return r[31:0];
	endfunction

endpackage

@@ rtl/quaternion_transform_to_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_transform_to_matrix_unit
// Quaternion, per-axis scale and position to the nine rotation-scale entries
// and translation column of a column-major model matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one transform word: quaternion in Q1.14,
//   scale in Q8.8, position in Q16.16. out_valid/out_ready/out_data carry the
//   matrix word in Q16.16, rounded to nearest, columns scaled by their axis.
//   The quaternion is used as given, without normalisation.
//   Four register stages: products, entry sums, the 35x16 scale multiply,
//   then rounding into the output register. The accepting edge loads the
//   first stage, and out_valid rises once the word reaches the last one.
//   Throughput is one word per cycle; a new word is taken in every cycle in
//   which the output register is empty or being drained.
//   When the receiver stalls with out_valid high, the whole pipeline holds
//   and in_ready drops in the same cycle; no word is lost or repeated.
//   Reset clears all stage valid bits; the pipeline comes up empty and
//   ready.
// ----------------------------------------------------------------------------
module quaternion_transform_to_matrix_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qtm_pkg::qtm_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output qtm_pkg::qtm_out_t out_data
);
	import qtm_pkg::*;

	logic      adv;
	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	qtm_prod_t prod_s1;
	qtm_term_t term_s2;

	// advance everything unless the output word is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	qtm_prod u_prod (
		.clk  (clk),
		.en   (adv),
		.d    (in_data),
		.q_s1 (prod_s1)
	);

	qtm_terms u_terms (
		.clk  (clk),
		.en   (adv),
		.d    (prod_s1),
		.q_s2 (term_s2)
	);

	qtm_scale u_scale (
		.clk  (clk),
		.en   (adv),
		.d    (term_s2),
		.q_s4 (out_data)
	);

	// output word must come from a live third stage
	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) && out_valid |-> $past(v_s3))
		else $error("output valid without a word in stage three");

	// a stall freezes the inner stages
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_s3))
		else $error("inner stage valid moved during a stall");

	// translation reaches the output unchanged when no stall follows acceptance
	a_trans_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 adv ##1 adv ##1 adv |=>
		out_valid && out_data.trans_x == $past(in_data.pos_x, 4)
		&& out_data.trans_z == $past(in_data.pos_z, 4))
		else $error("translation column lost or misaligned");

endmodule

@@ rtl/qtm_prod.sv @@
// ----------------------------------------------------------------------------
// qtm_prod
// First stage: the nine doubled quaternion products.
// ----------------------------------------------------------------------------
module qtm_prod (
	input  logic             clk,
	input  logic             en,
	input  qtm_pkg::qtm_in_t d,
	output qtm_pkg::qtm_prod_t q_s1
);
	import qtm_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1.xx      <= dbl_mul(d.quat_x, d.quat_x);
			q_s1.xy      <= dbl_mul(d.quat_x, d.quat_y);
			q_s1.xz      <= dbl_mul(d.quat_x, d.quat_z);
			q_s1.yy      <= dbl_mul(d.quat_y, d.quat_y);
			q_s1.yz      <= dbl_mul(d.quat_y, d.quat_z);
			q_s1.zz      <= dbl_mul(d.quat_z, d.quat_z);
			q_s1.wx      <= dbl_mul(d.quat_w, d.quat_x);
			q_s1.wy      <= dbl_mul(d.quat_w, d.quat_y);
			q_s1.wz      <= dbl_mul(d.quat_w, d.quat_z);
			q_s1.scale_x <= d.scale_x;
			q_s1.scale_y <= d.scale_y;
			q_s1.scale_z <= d.scale_z;
			q_s1.pos_x   <= d.pos_x;
			q_s1.pos_y   <= d.pos_y;
			q_s1.pos_z   <= d.pos_z;
		end
	end

endmodule

@@ rtl/qtm_terms.sv @@
// ----------------------------------------------------------------------------
// qtm_terms
// Second stage: combine products into the nine rotation entries.
// ----------------------------------------------------------------------------
module qtm_terms (
	input  logic               clk,
	input  logic               en,
	input  qtm_pkg::qtm_prod_t d,
	output qtm_pkg::qtm_term_t q_s2
);
	import qtm_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2.ent[0]  <= ONE_Q28 - (ext_term(d.yy) + ext_term(d.zz));
			q_s2.ent[1]  <= ext_term(d.xy) + ext_term(d.wz);
			q_s2.ent[2]  <= ext_term(d.xz) - ext_term(d.wy);
			q_s2.ent[3]  <= ext_term(d.xy) - ext_term(d.wz);
			q_s2.ent[4]  <= ONE_Q28 - (ext_term(d.xx) + ext_term(d.zz));
			q_s2.ent[5]  <= ext_term(d.yz) + ext_term(d.wx);
			q_s2.ent[6]  <= ext_term(d.xz) + ext_term(d.wy);
			q_s2.ent[7]  <= ext_term(d.yz) - ext_term(d.wx);
			q_s2.ent[8]  <= ONE_Q28 - (ext_term(d.xx) + ext_term(d.yy));
			q_s2.scale_x <= d.scale_x;
			q_s2.scale_y <= d.scale_y;
			q_s2.scale_z <= d.scale_z;
			q_s2.pos_x   <= d.pos_x;
			q_s2.pos_y   <= d.pos_y;
			q_s2.pos_z   <= d.pos_z;
		end
	end

endmodule

@@ rtl/qtm_scale.sv @@
// ----------------------------------------------------------------------------
// qtm_scale
// Third and fourth stages: scale each column by its axis, then round the
// Q.36 result to Q16.16 into the output register.
// ----------------------------------------------------------------------------
module qtm_scale (
	input  logic               clk,
	input  logic               en,
	input  qtm_pkg::qtm_term_t d,
	output qtm_pkg::qtm_out_t  q_s4
);
	import qtm_pkg::*;

	qtm_scl_t sc_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				// column i/3 takes scale of its own axis
				case (i / 3)
					0:       sc_s3.ent[i] <= scl_mul(d.ent[i], d.scale_x);
					1:       sc_s3.ent[i] <= scl_mul(d.ent[i], d.scale_y);
					default: sc_s3.ent[i] <= scl_mul(d.ent[i], d.scale_z);
				endcase
			end
			sc_s3.pos_x <= d.pos_x;
			sc_s3.pos_y <= d.pos_y;
			sc_s3.pos_z <= d.pos_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4.col0_x  <= rnd_q16(sc_s3.ent[0]);
			q_s4.col0_y  <= rnd_q16(sc_s3.ent[1]);
			q_s4.col0_z  <= rnd_q16(sc_s3.ent[2]);
			q_s4.col1_x  <= rnd_q16(sc_s3.ent[3]);
			q_s4.col1_y  <= rnd_q16(sc_s3.ent[4]);
			q_s4.col1_z  <= rnd_q16(sc_s3.ent[5]);
			q_s4.col2_x  <= rnd_q16(sc_s3.ent[6]);
			q_s4.col2_y  <= rnd_q16(sc_s3.ent[7]);
			q_s4.col2_z  <= rnd_q16(sc_s3.ent[8]);
			q_s4.trans_x <= sc_s3.pos_x;
			q_s4.trans_y <= sc_s3.pos_y;
			q_s4.trans_z <= sc_s3.pos_z;
		end
	end

endmodule
